// File: rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// Used by sha1_ctrl, sha1_datapath and sha1_hash_engine_core; no dependencies.
package sha1_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned RoundBits  = 7;
  localparam int unsigned FillBits   = 6;
  localparam int unsigned CountBits  = 61;

  localparam logic [FillBits-1:0]  FillLast   = 6'd63;
  localparam logic [FillBits-1:0]  FillLenPos = 6'd56;
  localparam logic [RoundBits-1:0] RoundLast  = 7'(NumRounds - 1);
  localparam logic [2:0]           LastWordIdx = 3'd4;

  localparam logic [7:0] PadMark = 8'h80;

  typedef logic [NumWords-1:0][31:0] chain_t;

  // h4 in the top slot, h0 in slot 0
  localparam chain_t HashInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } push_sel_e;

  typedef struct packed {
    logic                 push_en;
    push_sel_e            push_sel;
    logic                 count_en;
    logic                 round_en;
    logic [RoundBits-1:0] round_idx;
    logic                 add_chain;
    logic                 clear;
    logic [2:0]           word_idx;
  } cmd_t;

  typedef struct packed {
    logic [FillBits-1:0] fill;
  } status_t;

endpackage

// File: rtl/sha1_datapath.sv
// SHA-1 datapath: 512-bit block shift line doubling as the message schedule window,
// working variables, chaining words and length counter. Depends on sha1_pkg.
module sha1_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::cmd_t    cmd_i,
  input  logic [7:0]        data_byte_i,
  output sha1_pkg::status_t status_o,
  output logic [31:0]       digest_word_o
);
  import sha1_pkg::*;

  logic [511:0]          msg_q, msg_d;
  logic [FillBits-1:0]   fill_q, fill_d;
  logic [CountBits-1:0]  count_q, count_d;
  chain_t                chain_q, chain_d;
  chain_t                work_q, work_d;

  logic [63:0] len_bits, len_shift;
  logic [7:0]  push_byte;
  logic [31:0] w_cur, w_new, f_val, k_val, temp;
  logic [31:0] a, b, c, d, e;

  assign len_bits  = {count_q, 3'b000};
  // length goes out big-endian, byte 56 of the block carries the top byte
  assign len_shift = len_bits << {fill_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.push_sel)
      SEL_DATA: push_byte = data_byte_i;
      SEL_MARK: push_byte = PadMark;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_shift[63:56];
      default:  push_byte = 8'h00;
    endcase
  end

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  // window word j sits at msg_q[511-32j -: 32]; word 0 is W[t]
  assign w_cur = msg_q[511:480];
  always_comb begin
    logic [31:0] x;
    x     = msg_q[95:64] ^ msg_q[255:224] ^ msg_q[447:416] ^ msg_q[511:480];
    w_new = {x[30:0], x[31]};
  end

  always_comb begin
    if (cmd_i.round_idx < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = K0;
    end else if (cmd_i.round_idx < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = K1;
    end else if (cmd_i.round_idx < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K3;
    end
  end

  assign temp = {a[26:0], a[31:27]} + f_val + e + k_val + w_cur;

  always_comb begin
    msg_d   = msg_q;
    fill_d  = fill_q;
    count_d = count_q;
    chain_d = chain_q;
    work_d  = work_q;
    if (cmd_i.push_en) begin
      msg_d  = {msg_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
      // block complete: start the working variables from the chain
      if (fill_q == FillLast) begin
        work_d = chain_q;
      end
    end
    if (cmd_i.count_en) begin
      count_d = count_q + 61'd1;
    end
    if (cmd_i.round_en) begin
      msg_d  = {msg_q[479:0], w_new};
      work_d = {d, c, {b[1:0], b[31:2]}, a, temp};
    end
    if (cmd_i.add_chain) begin
      for (int i = 0; i < NumWords; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end
    if (cmd_i.clear) begin
      chain_d = HashInit;
      count_d = '0;
      fill_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
      chain_q <= HashInit;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q  <= msg_d;
    work_q <= work_d;
  end

  assign status_o.fill = fill_q;
  assign digest_word_o = chain_q[cmd_i.word_idx];

endmodule

// File: rtl/sha1_ctrl.sv
// SHA-1 controller: sequences byte intake, rounds, padding and digest output.
// Depends on sha1_pkg; drives sha1_datapath through cmd_t.
module sha1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              carries_byte_i,
  input  logic              end_of_message_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        word_index_o,
  output logic              last_word_o,
  input  sha1_pkg::status_t status_i,
  output sha1_pkg::cmd_t    cmd_o
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUNDS,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_e;

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic                 ending_q, ending_d;
  logic [RoundBits-1:0] round_q, round_d;
  logic [2:0]           word_q, word_d;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ending_d = ending_q;
    round_d  = round_q;
    word_d   = word_q;

    cmd_o.push_en   = 1'b0;
    cmd_o.push_sel  = SEL_DATA;
    cmd_o.count_en  = 1'b0;
    cmd_o.round_en  = 1'b0;
    cmd_o.round_idx = round_q;
    cmd_o.add_chain = 1'b0;
    cmd_o.clear     = 1'b0;
    cmd_o.word_idx  = word_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ending_d = end_of_message_i;
          phase_d  = PH_MARK;
          if (carries_byte_i) begin
            cmd_o.push_en  = 1'b1;
            cmd_o.count_en = 1'b1;
          end
          if (carries_byte_i && status_i.fill == FillLast) begin
            state_d = ST_ROUNDS;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUNDS: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 7'd1;
        if (round_q == RoundLast) begin
          round_d = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
        if (!ending_q) begin
          state_d = ST_IDLE;
        end else if (phase_q == PH_LEN) begin
          // the length block has just been folded in
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd_o.push_en = 1'b1;
        unique case (phase_q)
          PH_MARK: begin
            cmd_o.push_sel = SEL_MARK;
            phase_d        = PH_ZERO;
          end
          PH_ZERO: begin
            if (status_i.fill == FillLenPos) begin
              cmd_o.push_sel = SEL_LEN;
              phase_d        = PH_LEN;
            end else begin
              cmd_o.push_sel = SEL_ZERO;
            end
          end
          PH_LEN: begin
            cmd_o.push_sel = SEL_LEN;
          end
          default: begin
            cmd_o.push_sel = SEL_ZERO;
          end
        endcase
        if (status_i.fill == FillLast) begin
          state_d = ST_ROUNDS;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (word_q == LastWordIdx) begin
            cmd_o.clear = 1'b1;
            word_d      = '0;
            ending_d    = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_MARK;
      ending_q <= 1'b0;
      round_q  <= '0;
      word_q   <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ending_q <= ending_d;
      round_q  <= round_d;
      word_q   <= word_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_EMIT);
  assign word_index_o = word_q;
  assign last_word_o  = (word_q == LastWordIdx);

endmodule

// File: rtl/sha1_hash_engine_core.sv
// Streaming SHA-1 engine: at most one message byte per input transfer, five digest words out
// per message. The transfer that completes a 64-byte block is followed by 80 rounds on
// the single round unit and one chain add before the next byte is taken. An
// end-of-message transfer then pushes the padding and length one byte per cycle,
// runs one or two compressions, and presents the digest words h0..h4, one per
// output transfer, the fifth flagged last. The engine then returns to its
// initial state for the next message; no input is taken while a digest is pending.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
module sha1_hash_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        carries_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1_pkg::*;

  cmd_t    cmd;
  status_t status;

  sha1_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .carries_byte_i   (carries_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  sha1_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .status_o      (status),
    .digest_word_o (digest_word_o)
  );

  // no input transfer while a digest is being handed out
  a_no_input_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest pending");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == LastWordIdx)))
    else $error("last flag out of step with word index");

  // after the final word the engine is ready again with a fresh state
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> (!out_valid_o && !in_stall_o))
    else $error("engine not idle after final digest word");

  a_first_word_h0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_index_o == 3'd0))
    else $error("digest does not start at h0");

endmodule

// File: tb/sha1_digest_sb_pkg.sv
`timescale 1ns / 1ps
// SHA-1 digest scoreboard: a behavioural hash of the byte stream and the queue of
// digest words it expects. Depends on sha1_pkg for the initial hash and round constants.
package sha1_digest_sb_pkg;

  import sha1_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  class sha1_digest_scoreboard;
    bit [31:0]    hash_h [5];
    bit [60:0]    msg_len;
    bit [7:0]     blk [64];
    int unsigned  blk_fill;
    digest_word_t expected_digest_q [$];
    int unsigned  mismatches;
    int unsigned  words_checked;

    function void restart();
      int i;
      for (i = 0; i < 5; i++) hash_h[i] = HashInit[i];
      msg_len  = '0;
      blk_fill = 0;
    endfunction

    // 80 rounds over the buffered block, folded into the chaining words
    function void compress();
      bit [31:0] w [80];
      bit [31:0] a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (i = 16; i < 80; i++) begin
        t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
        w[i] = {t[30:0], t[31]};
      end
      a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
      for (i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);          k = K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;                   k = K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = K2;
        end else begin
          f = b ^ c ^ d;                   k = K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[i];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
    endfunction

    // buffer placement only; the length counter is kept by the caller
    function void absorb_byte(bit [7:0] v);
      blk[blk_fill] = v;
      blk_fill++;
      if (blk_fill == 64) begin
        compress();
        blk_fill = 0;
      end
    endfunction

    function void absorb_transfer(bit [7:0] data, bit carries, bit ending);
      bit [63:0]    bit_len;
      digest_word_t dw;
      int i;
      if (carries) begin
        msg_len++;
        absorb_byte(data);
      end
      if (!ending) return;
      bit_len = {msg_len, 3'b000};
      absorb_byte(8'h80);
      while (blk_fill != 56) absorb_byte(8'h00);
      for (i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
      for (i = 0; i < 5; i++) begin
        dw.word = hash_h[i];
        dw.pos  = 3'(i);
        dw.last = (i == 4);
        expected_digest_q = {expected_digest_q, dw};
      end
      restart();
    endfunction

    function void check_digest_word(logic [31:0] word, logic [2:0] pos, logic last);
      digest_word_t exp_dw;
      words_checked++;
      if (expected_digest_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected digest word: expected none, got %08h pos %0d last %0b",
                 $time, word, pos, last);
        return;
      end
      exp_dw = expected_digest_q.pop_front();
      if (word !== exp_dw.word) begin
        mismatches++;
        $display("%0t: digest_word: expected %08h, got %08h", $time, exp_dw.word, word);
      end
      if (pos !== exp_dw.pos) begin
        mismatches++;
        $display("%0t: word_index: expected %0d, got %0d", $time, exp_dw.pos, pos);
      end
      if (last !== exp_dw.last) begin
        mismatches++;
        $display("%0t: last_word: expected %0b, got %0b", $time, exp_dw.last, last);
      end
    endfunction

    function int unsigned pending();
      return expected_digest_q.size();
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench for sha1_hash_engine_core: directed and random byte streams,
// random idling on both channels and one long output hold-off.
// Depends on sha1_pkg and sha1_digest_sb_pkg.
module testbench;

  import sha1_digest_sb_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TargetItems = 360;
  localparam int unsigned DrainCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        carries_byte_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha1_digest_scoreboard sb = new;

  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 64;
  int unsigned items_sent    = 0;
  bit          hold_done     = 1'b0;

  sha1_hash_engine_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .carries_byte_i   (carries_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] data, input logic carries, input logic ending);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= data;
    carries_byte_i   <= carries;
    end_of_message_i <= ending;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.absorb_transfer(data, carries, ending);
    if (carries || ending) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len, input bit bare_end);
    int unsigned j;
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !bare_end && (j == len - 1));
    end
    if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int unsigned len;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    carries_byte_i   = 1'b0;
    end_of_message_i = 1'b0;
    sb.restart();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bare item on a fresh engine, then two empty messages back to back
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b1);
    // "abc", ended on a carrying transfer
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // byte extremes, a bare item mid-message, bare end marker
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);

    while (items_sent < TargetItems) begin
      if (items_sent < TargetItems / 3) begin
        send_idle_pct = 27; recv_idle_pct = 64;
      end else if (items_sent < 2 * TargetItems / 3) begin
        send_idle_pct = 64; recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      // lengths cluster round the one- and two-block padding boundaries
      case ($urandom_range(0, 9))
        6:       len = $urandom_range(54, 57);
        7:       len = $urandom_range(63, 65);
        8:       len = $urandom_range(118, 121);
        9:       len = $urandom_range(20, 50);
        default: len = $urandom_range(0, 12);
      endcase
      // keep the total close to the target
      if (len > TargetItems - items_sent) len = TargetItems - items_sent;
      send_message(len, (len == 0) || ($urandom_range(0, 2) == 0));
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // output side: random stall, plus one long hold-off so the input backs up
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.words_checked >= 30) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_digest_word(digest_word_o, word_index_o, last_word_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
